>>> hw/rtl/mmh_pkg.sv
// Shared types and constants for the min-max heap priority queue.
// No dependencies.
`timescale 1ns / 1ps
package mmh_pkg;
    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_REM_MIN = 2'd1;
    localparam logic [1:0] MODE_REM_MAX = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    localparam int VAL_W = 32;

    // compare request to the shared comparator
    typedef struct packed {
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        logic                    toward_max;
    } cmp_req_t;
endpackage

>>> hw/rtl/mmh_cmp.sv
// Shared strict-order comparator of the heap sequencer.
// Depends on mmh_pkg.
`timescale 1ns / 1ps
module mmh_cmp
    import mmh_pkg::*;
(
    input  cmp_req_t req,
    output logic     better
);
    // a strictly better than b in the requested direction
    assign better = req.toward_max ? (req.a > req.b) : (req.a < req.b);
endmodule

>>> hw/rtl/min_max_heap_priority_queue.sv
// Top level of the min-max heap priority queue: stream ports, entry memory
// and the sequencer driving the shared comparator. Depends on mmh_pkg, mmh_cmp.
`timescale 1ns / 1ps
// Double-ended priority queue of signed 32-bit values held as a min-max heap
// in a single-port entry memory (one read or one write per cycle, registered
// read). Each input word inserts a value (mode 0), removes the minimum (1) or
// removes the maximum (2); mode 3 does nothing. One output word follows each
// input word with status, occupancy, current minimum and maximum, and the
// removed value. The block takes one word at a time. An insert may first swap
// with its parent and then climbs grandparent levels; a removal descends
// grandchild levels. The sequencer walks each step through the single memory
// port, and the output word is held until m_tready. No clearing pass is
// needed after reset.
module min_max_heap_priority_queue
    import mmh_pkg::*;
#(
    parameter int CAPACITY = 1023
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[1:0], value[33:2], zeros[39:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [111:0] m_tdata   // status[1:0], occupancy[11:2], smallest[43:12],
                                   // largest[75:44], removed[107:76], zeros[111:108]
);
    localparam int IW = $clog2(CAPACITY + 1) + 2;   // index width with headroom
    localparam int AW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] CAP = IW'(CAPACITY);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_IN_WR  = 5'd1;
    localparam logic [4:0] S_BU_RDP = 5'd2;
    localparam logic [4:0] S_BU_CMP = 5'd3;
    localparam logic [4:0] S_CL_RD  = 5'd4;
    localparam logic [4:0] S_CL_CMP = 5'd5;
    localparam logic [4:0] S_SWAP_A = 5'd6;
    localparam logic [4:0] S_SWAP_B = 5'd7;
    localparam logic [4:0] S_RM_R2  = 5'd8;
    localparam logic [4:0] S_RM_R3  = 5'd9;
    localparam logic [4:0] S_RM_RK  = 5'd10;
    localparam logic [4:0] S_RM_RT  = 5'd11;
    localparam logic [4:0] S_RM_WK  = 5'd12;
    localparam logic [4:0] S_TD_RI  = 5'd13;
    localparam logic [4:0] S_TD_RC  = 5'd14;
    localparam logic [4:0] S_TD_CC  = 5'd15;
    localparam logic [4:0] S_TD_DEC = 5'd16;
    localparam logic [4:0] S_TD_RP  = 5'd17;
    localparam logic [4:0] S_TD_CP  = 5'd18;
    localparam logic [4:0] S_ST_R1  = 5'd19;
    localparam logic [4:0] S_ST_R2  = 5'd20;
    localparam logic [4:0] S_ST_R3  = 5'd21;
    localparam logic [4:0] S_ST_FIN = 5'd22;
    localparam logic [4:0] S_OUT    = 5'd23;

    // swap continuations
    localparam logic [1:0] K_CLIMB = 2'd0;
    localparam logic [1:0] K_TDGC  = 2'd1;
    localparam logic [1:0] K_TDPAR = 2'd2;
    localparam logic [1:0] K_DONE  = 2'd3;

    logic signed [VAL_W-1:0] mem [1:CAPACITY];
    logic signed [VAL_W-1:0] rd_data;
    logic                    mem_we;
    logic [AW-1:0]           mem_addr;
    logic signed [VAL_W-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data <= mem[mem_addr];
    end

    logic [4:0]  state_reg, state_next;
    logic [IW-1:0] fill_reg, fill_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, m_reg, m_next;
    logic [2:0]  ck_reg, ck_next;
    logic        dir_reg, dir_next;
    logic [1:0]  kont_reg, kont_next;
    logic [1:0]  status_reg, status_next;
    logic signed [VAL_W-1:0] vi_reg, vi_next, vm_reg, vm_next;
    logic signed [VAL_W-1:0] rem_reg, rem_next, lo_reg, lo_next, hi_reg, hi_next;
    logic        ovalid_reg, ovalid_next;

    cmp_req_t creq;
    logic     cbetter;
    mmh_cmp u_cmp (.req(creq), .better(cbetter));

    // level parity of an index: even bit length means an odd level
    function automatic logic is_max_level(input logic [IW-1:0] idx);
        logic r;
        r = 1'b0;
        for (int b = 0; b < IW; b++)
            if (idx[b])
                r = (b % 2) == 1;
        return r;
    endfunction

    // candidate index for the trickle scan: two children, four grandchildren
    logic [IW-1:0] cand;
    always_comb
    begin
        case (ck_reg)
            3'd0:    cand = {i_reg[IW-2:0], 1'b0};
            3'd1:    cand = {i_reg[IW-2:0], 1'b1};
            3'd2:    cand = {i_reg[IW-3:0], 2'd0};
            3'd3:    cand = {i_reg[IW-3:0], 2'd1};
            3'd4:    cand = {i_reg[IW-3:0], 2'd2};
            default: cand = {i_reg[IW-3:0], 2'd3};
        endcase
    end

    logic [IW-1:0] i_half, i_quarter;
    assign i_half    = i_reg >> 1;
    assign i_quarter = i_reg >> 2;

    always_comb
    begin
        state_next = state_reg; fill_next = fill_reg;
        i_next = i_reg; j_next = j_reg; m_next = m_reg; ck_next = ck_reg;
        dir_next = dir_reg; kont_next = kont_reg;
        status_next = status_reg; vi_next = vi_reg; vm_next = vm_reg;
        rem_next = rem_reg; lo_next = lo_reg; hi_next = hi_reg;
        ovalid_next = ovalid_reg;
        mem_we = 1'b0; mem_addr = '0; mem_wdata = vi_reg;
        creq.a = vi_reg; creq.b = rd_data; creq.toward_max = dir_reg;
        s_tready = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    vi_next = s_tdata[33:2];
                    status_next = ST_OK;
                    rem_next = '0;
                    if (s_tdata[1:0] == MODE_INSERT)
                    begin
                        if (fill_reg >= CAP)
                        begin
                            status_next = ST_OVERFLOW;
                            state_next = S_ST_R1;
                        end
                        else
                        begin
                            fill_next = fill_reg + 1'b1;
                            i_next = fill_reg + 1'b1;
                            state_next = S_IN_WR;
                        end
                    end
                    else if (s_tdata[1:0] == MODE_REM_MIN || s_tdata[1:0] == MODE_REM_MAX)
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next = S_ST_R1;
                        end
                        else
                        begin
                            i_next = IW'(1);
                            state_next = (s_tdata[1:0] == MODE_REM_MAX && fill_reg >= IW'(2))
                                         ? S_RM_R2 : S_RM_RK;
                        end
                    end
                    else
                        state_next = S_ST_R1;
                end
            end
            // insert: write value at tail, then compare with parent
            S_IN_WR:
            begin
                mem_we = 1'b1; mem_addr = AW'(i_reg); mem_wdata = vi_reg;
                dir_next = is_max_level(i_reg);   // level parity of the new tail
                state_next = (i_reg > IW'(1)) ? S_BU_RDP : S_ST_R1;
            end
            S_BU_RDP:
            begin
                mem_addr = AW'(i_half);
                state_next = S_BU_CMP;
            end
            S_BU_CMP:
            begin
                // on a min level, test value > parent (dir toward max)
                creq.toward_max = !dir_reg;
                if (cbetter)
                begin
                    vm_next = rd_data; m_next = i_half; j_next = i_half;
                    dir_next = !dir_reg;
                    kont_next = K_CLIMB; state_next = S_SWAP_A;
                end
                else
                begin
                    dir_next = dir_reg;   // climb in the direction of its own level
                    state_next = S_CL_RD;
                end
            end
            // climb through grandparents; vi holds the moving value at i
            S_CL_RD:
            begin
                mem_addr = AW'(i_quarter);
                state_next = (i_reg >= IW'(4)) ? S_CL_CMP : S_ST_R1;
            end
            S_CL_CMP:
            begin
                if (cbetter)
                begin
                    vm_next = rd_data; m_next = i_quarter; j_next = i_quarter;
                    kont_next = K_CLIMB; state_next = S_SWAP_A;
                end
                else
                    state_next = S_ST_R1;
            end
            // swap: write vi at m, vm at i; then i moves to j
            S_SWAP_A:
            begin
                mem_we = 1'b1; mem_addr = AW'(m_reg); mem_wdata = vi_reg;
                state_next = S_SWAP_B;
            end
            S_SWAP_B:
            begin
                mem_we = 1'b1; mem_addr = AW'(i_reg); mem_wdata = vm_reg;
                i_next = j_reg;
                case (kont_reg)
                    K_CLIMB: state_next = S_CL_RD;
                    K_TDGC:  state_next = S_TD_RP;
                    K_TDPAR:
                    begin
                        vi_next = vm_reg;   // displaced parent value carries on down
                        state_next = S_TD_RI;
                    end
                    default: state_next = S_ST_R1;
                endcase
            end
            // removal
            S_RM_R2:
            begin
                mem_addr = AW'(2);
                i_next = IW'(2);
                state_next = (fill_reg >= IW'(3)) ? S_RM_R3 : S_RM_RK;
            end
            S_RM_R3:
            begin
                mem_addr = AW'(3);
                vm_next = rd_data;
                state_next = S_RM_RK;
            end
            S_RM_RK:
            begin
                if (state_reg == S_RM_RK && i_reg == IW'(2) && fill_reg >= IW'(3)
                    && rd_data > vm_reg)
                    i_next = IW'(3);
                state_next = S_RM_RT;
            end
            S_RM_RT:
            begin
                mem_addr = AW'(i_reg);
                state_next = S_RM_WK;
            end
            S_RM_WK:
            begin
                // rd_data = entry k; read tail next
                rem_next = rd_data;
                mem_addr = AW'(fill_reg);
                state_next = S_TD_RI;
                fill_next = fill_reg - 1'b1;
                ck_next = 3'd7;
            end
            S_TD_RI:
            begin
                if (ck_reg == 3'd7)
                begin
                    // tail value arrived: place it at k
                    vi_next = rd_data;
                    mem_we = 1'b1; mem_addr = AW'(i_reg); mem_wdata = rd_data;
                    if (i_reg > fill_reg)
                        state_next = S_ST_R1;
                end
                dir_next = is_max_level(i_reg);
                ck_next = 3'd0;
                if (ck_reg != 3'd7 || i_reg <= fill_reg)
                    state_next = ({i_reg[IW-2:0], 1'b0} <= fill_reg) ? S_TD_RC : S_ST_R1;
            end
            S_TD_RC:
            begin
                mem_addr = AW'(cand);
                state_next = S_TD_CC;
            end
            S_TD_CC:
            begin
                // running best vm at m; first candidate always taken
                creq.a = rd_data; creq.b = vm_reg;
                if (ck_reg == 3'd0 || cbetter)
                begin
                    vm_next = rd_data; m_next = cand;
                end
                // after the right child the scan jumps to the first grandchild
                if (ck_reg == 3'd5 ||
                    ((ck_reg == 3'd1) ? {i_reg[IW-3:0], 2'd0} : cand + 1'b1) > fill_reg)
                    state_next = S_TD_DEC;
                else
                begin
                    ck_next = ck_reg + 1'b1;
                    state_next = S_TD_RC;
                end
            end
            S_TD_DEC:
            begin
                creq.a = vm_reg; creq.b = vi_reg;
                if (cbetter)
                begin
                    j_next = m_reg;
                    kont_next = (m_reg >= {i_reg[IW-3:0], 2'd0}) ? K_TDGC : K_DONE;
                    state_next = S_SWAP_A;
                end
                else
                    state_next = S_ST_R1;
            end
            // after a grandchild swap: vi at m, check against m's parent
            S_TD_RP:
            begin
                mem_addr = AW'(i_reg >> 1);
                state_next = S_TD_CP;
            end
            S_TD_CP:
            begin
                creq.a = rd_data; creq.b = vi_reg;
                if (cbetter)
                begin
                    vm_next = rd_data; m_next = i_reg >> 1; j_next = i_reg;
                    kont_next = K_TDPAR; state_next = S_SWAP_A;
                end
                else
                    state_next = S_TD_RI;
                ck_next = 3'd0;
            end
            // status read of entries 1..3; each registered read is used in the next state
            S_ST_R1:
            begin
                mem_addr = AW'(1);
                state_next = S_ST_R2;
            end
            S_ST_R2:
            begin
                mem_addr = AW'(2);
                lo_next = (fill_reg >= IW'(1)) ? rd_data : '0;
                hi_next = (fill_reg >= IW'(1)) ? rd_data : '0;
                state_next = S_ST_R3;
            end
            S_ST_R3:
            begin
                mem_addr = AW'(3);
                if (fill_reg >= IW'(2))
                    hi_next = rd_data;
                state_next = S_ST_FIN;
            end
            S_ST_FIN:
            begin
                if (fill_reg >= IW'(3) && rd_data > hi_reg)
                    hi_next = rd_data;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg)
                    ovalid_next = 1'b1;
                else if (m_tready)
                begin
                    ovalid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            ovalid_reg <= 1'b0;
            ck_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            ovalid_reg <= ovalid_next;
            ck_reg <= ck_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next; m_reg <= m_next;
        dir_reg <= dir_next; kont_reg <= kont_next;
        status_reg <= status_next; vi_reg <= vi_next; vm_reg <= vm_next;
        rem_reg <= rem_next; lo_reg <= lo_next; hi_reg <= hi_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata = {4'd0, rem_reg, hi_reg, lo_reg, 10'(fill_reg), status_reg};

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CAP) else $error("fill count beyond capacity");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid) else $error("input ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(fill_reg))
        else $error("result dropped or count moved while stalled");
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != $past(fill_reg) |-> fill_reg == $past(fill_reg) + 1'b1
        || fill_reg == $past(fill_reg) - 1'b1) else $error("fill count jumped");
endmodule
